FILE: design/twgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package twgc_pkg;
  localparam int FracBitsDefault = 12;
  localparam int CordicSteps = 28;
  localparam int AngFrac = 30;
  localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
  localparam int TgtW = 17;
  localparam int GainW = 16;
  localparam int PoseW = 18;
  localparam int HeadW = 15;
  localparam int OutW = 24;
  localparam int DW = 19;
  localparam int SqW = 39;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_T1X = 3'd0, REG_T1Y = 3'd1, REG_T2X = 3'd2, REG_T2Y = 3'd3,
    REG_LGAIN = 3'd4, REG_AGAIN = 3'd5, REG_RADIUS = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic load;
    logic start_iter;
    logic iter;
    logic mul;
    logic out_stop;
    logic out_cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_done;
    logic arrive1;
    logic arrive2;
  } dp_status_t;

  function automatic logic [35:0] atan_entry(input logic [4:0] i);
    logic [35:0] r;
    begin
      r = 36'd0;
      unique case (i)
        5'd0: r = 36'd843314857;
        5'd1: r = 36'd497837829;
        5'd2: r = 36'd263043837;
        5'd3: r = 36'd133525159;
        5'd4: r = 36'd67021687;
        5'd5: r = 36'd33543516;
        5'd6: r = 36'd16775851;
        5'd7: r = 36'd8388437;
        5'd8: r = 36'd4194283;
        5'd9: r = 36'd2097149;
        5'd10: r = 36'd1048576;
        default: r = 36'd1 << (AngFrac - 32'(i));
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

FILE: design/twgc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface twgc_pose_if;
  logic valid;
  logic ready;
  logic signed [17:0] pose_x;
  logic signed [17:0] pose_y;
  logic signed [14:0] heading;
  modport source (output valid, pose_x, pose_y, heading, input ready);
  modport sink (input valid, pose_x, pose_y, heading, output ready);
endinterface

interface twgc_cmd_if;
  logic valid;
  logic ready;
  logic signed [23:0] linear_velocity;
  logic signed [23:0] angular_velocity;
  logic waypoint_phase;
  logic arrived;
  logic last;
  modport source (output valid, linear_velocity, angular_velocity, waypoint_phase,
                  arrived, last, input ready);
  modport sink (input valid, linear_velocity, angular_velocity, waypoint_phase,
                arrived, last, output ready);
endinterface
`default_nettype wire

FILE: design/twgc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module twgc_datapath #(
  parameter int FRAC_BITS = twgc_pkg::FracBitsDefault
) (
  input  wire logic clk,
  input  wire twgc_pkg::dp_cmd_t cmd,
  output twgc_pkg::dp_status_t status,
  input  wire logic phase,
  input  wire logic signed [17:0] pose_x,
  input  wire logic signed [17:0] pose_y,
  input  wire logic signed [14:0] heading,
  input  wire logic [16:0] t1x,
  input  wire logic [16:0] t1y,
  input  wire logic [16:0] t2x,
  input  wire logic [16:0] t2y,
  input  wire logic [15:0] lgain,
  input  wire logic [15:0] again,
  input  wire logic [15:0] radius,
  output logic signed [23:0] lin_out,
  output logic signed [23:0] ang_out
);
  import twgc_pkg::*;

  logic signed [DW-1:0] dx, dy;
  logic signed [14:0] hd;
  logic [SqW-1:0] rsq;
  logic [SqW-1:0] s1, s2;
  logic signed [45:0] cx, cy;
  logic signed [45:0] cz;
  logic [4:0] step;
  logic [SqW-1:0] rem, root, bit_q;
  logic signed [36:0] lin_p;
  logic signed [40:0] ang_p;
  logic arr1, arr2;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [45:0] sx, sy;
  logic signed [45:0] a_ext;
  logic signed [45:0] zr;
  logic signed [20:0] brg;
  logic signed [21:0] err;
  logic signed [40:0] lin_sh;
  logic signed [40:0] ang_sh;

  assign d1x = DW'($signed({2'b0, t1x})) - DW'(pose_x);
  assign d1y = DW'($signed({2'b0, t1y})) - DW'(pose_y);
  assign d2x = DW'($signed({2'b0, t2x})) - DW'(pose_x);
  assign d2y = DW'($signed({2'b0, t2y})) - DW'(pose_y);
  assign sx = cx >>> step;
  assign sy = cy >>> step;
  assign a_ext = 46'(atan_entry(step));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx <= phase ? d2x : d1x;
      dy <= phase ? d2y : d1y;
      hd <= heading;
      rsq <= SqW'(radius) * SqW'(radius);
      s1 <= SqW'(d1x) * SqW'(d1x) + SqW'(d1y) * SqW'(d1y);
      s2 <= SqW'(d2x) * SqW'(d2x) + SqW'(d2y) * SqW'(d2y);
    end
    if (cmd.start_iter) begin
      rem <= SqW'(dx) * SqW'(dx) + SqW'(dy) * SqW'(dy);
      root <= '0;
      bit_q <= SqW'(1) << 38;
      step <= '0;
      if (dx < 0) begin
        cx <= -(46'(dx) <<< 20);
        cy <= -(46'(dy) <<< 20);
        cz <= (dy >= 0) ? 46'(PiQ30) : -46'(PiQ30);
      end else begin
        cx <= 46'(dx) <<< 20;
        cy <= 46'(dy) <<< 20;
        cz <= '0;
      end
    end
    if (cmd.iter) begin
      step <= step + 5'd1;
      if (cy >= 0) begin
        cx <= cx + sy; cy <= cy - sx; cz <= cz + a_ext;
      end else begin
        cx <= cx - sy; cy <= cy + sx; cz <= cz - a_ext;
      end
      if (bit_q != 0) begin
        if (rem >= root + bit_q) begin
          rem <= rem - (root + bit_q);
          root <= (root >> 1) + bit_q;
        end else begin
          root <= root >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      arr1 <= s1 < rsq;
      arr2 <= s2 < rsq;
    end
    if (cmd.mul) begin
      lin_p <= $signed({1'b0, lgain}) * $signed({1'b0, root[19:0]});
      ang_p <= $signed({1'b0, again}) * err;
    end
  end

  assign zr = cz + (46'sd1 <<< (AngFrac - FRAC_BITS - 1));
  assign brg = (dx == 0 && dy == 0) ? 21'sd0 : 21'(zr >>> (AngFrac - FRAC_BITS));
  assign err = 22'(brg) - 22'(hd);
  assign lin_sh = 41'(lin_p) >>> FRAC_BITS;
  assign ang_sh = ang_p >>> FRAC_BITS;

  always_comb begin
    if (lin_sh > 41'sd8388607) lin_out = 24'sh7fffff;
    else lin_out = lin_sh[23:0];
    if (ang_sh > 41'sd8388607) ang_out = 24'sh7fffff;
    else if (ang_sh < -41'sd8388608) ang_out = 24'sh800000;
    else ang_out = ang_sh[23:0];
  end

  assign status.iter_done = (step == 5'(CordicSteps - 1));
  assign status.arrive1 = arr1;
  assign status.arrive2 = arr2;
  logic unused;
  assign unused = ^{cmd.out_stop, cmd.out_cmd};
endmodule
`default_nettype wire

FILE: design/twgc_control.sv
`timescale 1ns / 1ps
`default_nettype none
module twgc_control (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic out_ready,
  output logic out_valid,
  output logic out_stop,
  output logic phase,
  output logic cmd_phase,
  input  wire logic cfg_wr,
  input  wire logic cfg_hit,
  output twgc_pkg::dp_cmd_t cmd,
  input  wire twgc_pkg::dp_status_t status
);
  import twgc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SUM = 7'b0000010, S_ITER = 7'b0000100,
    S_MUL = 7'b0001000, S_CMD = 7'b0010000, S_STOP = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic finished, stop_pend;

  assign in_ready = (state == S_IDLE);
  assign cmd.load = in_valid && in_ready && !finished;
  assign cmd.start_iter = (state == S_SUM);
  assign cmd.iter = (state == S_ITER);
  assign cmd.mul = (state == S_MUL);
  assign cmd.out_cmd = (state == S_CMD);
  assign cmd.out_stop = (state == S_STOP);
  assign out_valid = (state == S_CMD) || (state == S_STOP);
  assign out_stop = (state == S_STOP);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.load) state_next = S_SUM;
      S_SUM: state_next = S_ITER;
      S_ITER: if (status.iter_done) state_next = S_WAIT;
      S_WAIT: state_next = S_MUL;
      S_MUL: state_next = S_CMD;
      S_CMD: if (out_ready) state_next = stop_pend ? S_STOP : S_IDLE;
      S_STOP: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      finished <= 1'b0;
      phase <= 1'b0;
      cmd_phase <= 1'b0;
      stop_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) cmd_phase <= phase;
      if (state == S_MUL) begin
        stop_pend <= status.arrive2;
        if (!phase && status.arrive1) phase <= 1'b1;
        if (status.arrive2) finished <= 1'b1;
      end
      if (cfg_wr && cfg_hit) begin
        finished <= 1'b0;
        if (finished) phase <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/two_waypoint_go_to_goal_controller.sv
// One request is handled at a time: a new pose is accepted only in the idle state, after
// the last result (and the stop result, when one follows) has been accepted;
// the 28-step CORDIC loop, which also runs the square root, sets the pace.
// Reset (rst, synchronous, active high) restores default registers and waypoint phase.
// No memory clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module two_waypoint_go_to_goal_controller #(
  parameter int FRAC_BITS = twgc_pkg::FracBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  twgc_pose_if.sink pose,
  twgc_cmd_if.source command,
  input wire logic cfg_we,
  input wire logic [twgc_pkg::CfgIdxW-1:0] cfg_index,
  input wire logic [twgc_pkg::CfgDataW-1:0] cfg_data
);
  import twgc_pkg::*;

  logic [16:0] t1x, t1y, t2x, t2y;
  logic [15:0] lgain, again, radius;
  dp_cmd_t cmd;
  dp_status_t status;
  logic phase, cmd_phase, out_stop, cfg_hit;
  logic signed [23:0] lin, ang;

  always_comb begin
    unique case (cfg_index) inside
      REG_T1X, REG_T1Y, REG_T2X, REG_T2Y, REG_LGAIN, REG_AGAIN, REG_RADIUS: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1x <= '0; t1y <= '0; t2x <= '0; t2y <= '0;
      lgain <= 16'd6144; again <= 16'd4506; radius <= 16'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_T1X: t1x <= cfg_data;
        REG_T1Y: t1y <= cfg_data;
        REG_T2X: t2x <= cfg_data;
        REG_T2Y: t2y <= cfg_data;
        REG_LGAIN: lgain <= cfg_data[15:0];
        REG_AGAIN: again <= cfg_data[15:0];
        REG_RADIUS: radius <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  twgc_control u_ctrl (
    .clk, .rst, .in_valid(pose.valid), .in_ready(pose.ready), .out_ready(command.ready),
    .out_valid(command.valid), .out_stop, .phase, .cmd_phase, .cfg_wr(cfg_we), .cfg_hit,
    .cmd, .status
  );

  twgc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .cmd, .status, .phase, .pose_x(pose.pose_x), .pose_y(pose.pose_y),
    .heading(pose.heading), .t1x, .t1y, .t2x, .t2y, .lgain, .again, .radius,
    .lin_out(lin), .ang_out(ang)
  );

  assign command.linear_velocity = out_stop ? '0 : lin;
  assign command.angular_velocity = out_stop ? '0 : ang;
  assign command.waypoint_phase = out_stop ? phase : cmd_phase;
  assign command.arrived = out_stop;
  assign command.last = out_stop || !status.arrive2;
endmodule
`default_nettype wire

FILE: design/twgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module twgc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic arrived,
  input wire logic last,
  input wire logic signed [23:0] lin
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_stop_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> last) else $error("stop result not last");
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> lin == 24'sd0) else $error("stop result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_nolast_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && arrived)
    else $error("stop result missing");
endmodule

bind two_waypoint_go_to_goal_controller twgc_checker u_chk (
  .clk, .rst, .in_valid(pose.valid), .in_ready(pose.ready),
  .out_valid(command.valid), .out_ready(command.ready),
  .arrived(command.arrived), .last(command.last), .lin(command.linear_velocity)
);
`default_nettype wire

FILE: dv/twgc_cmd_checker.sv
`timescale 1ns / 1ps
module twgc_cmd_checker
  import twgc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  twgc_pose_if                pose,
  twgc_cmd_if                 command,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  requests_used,
  output int                  commands_seen,
  output int                  stops_seen
);

  typedef struct packed {
    logic signed [OutW-1:0] lin;
    logic signed [OutW-1:0] ang;
    logic                   phase;
    logic                   arrived;
    logic                   last;
  } steer_cmd_t;

  localparam longint Atan0 = 843314857;
  localparam longint Atan1 = 497837829;
  localparam longint Atan2 = 263043837;
  localparam longint Atan3 = 133525159;
  localparam longint Atan4 = 67021687;
  localparam longint Atan5 = 33543516;
  localparam longint Atan6 = 16775851;
  localparam longint Atan7 = 8388437;
  localparam longint Atan8 = 4194283;
  localparam longint Atan9 = 2097149;
  localparam longint Atan10 = 1048576;

  longint     turn_table [11];
  steer_cmd_t cmd_queue  [$];
  logic [TgtW-1:0]  goal1_x, goal1_y, goal2_x, goal2_y;
  logic [GainW-1:0] speed_gain, turn_gain, radius;
  logic             heading_second, run_done;
  int               errs, used, cmds, stops;

  initial begin
    turn_table = '{Atan0, Atan1, Atan2, Atan3, Atan4, Atan5, Atan6, Atan7, Atan8,
                   Atan9, Atan10};
  end

  function automatic logic signed [OutW-1:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[OutW-1:0];
  endfunction

  function automatic longint floor_root(input longint v);
    logic [63:0] rem, root, bit_w;
    rem = v;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(root);
  endfunction

  function automatic longint bearing_to(input longint dx, input longint dy);
    longint x, y, z, xo, step;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx <<< 20;
    y = dy <<< 20;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? longint'(PiQ30) : -longint'(PiQ30);
    end
    for (int i = 0; i < CordicSteps; i++) begin
      step = (i < 11) ? turn_table[i] : (64'sd1 <<< (AngFrac - i));
      xo = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (xo >>> i);
        z = z + step;
      end else begin
        x = x - (y >>> i);
        y = y + (xo >>> i);
        z = z - step;
      end
    end
    return (z + (64'sd1 <<< (AngFrac - FracBitsDefault - 1))) >>> (AngFrac - FracBitsDefault);
  endfunction

  task automatic predict_steer(input longint px, input longint py, input longint hd);
    longint d1x, d1y, d2x, d2y, dx, dy, span, rsq, lin, ang;
    logic   cmd_phase, stop;
    steer_cmd_t c;
    cmd_phase = heading_second;
    d1x = longint'(goal1_x) - px;
    d1y = longint'(goal1_y) - py;
    d2x = longint'(goal2_x) - px;
    d2y = longint'(goal2_y) - py;
    dx = cmd_phase ? d2x : d1x;
    dy = cmd_phase ? d2y : d1y;
    span = floor_root(dx * dx + dy * dy);
    lin = (longint'(speed_gain) * span) >>> FracBitsDefault;
    ang = (longint'(turn_gain) * (bearing_to(dx, dy) - hd)) >>> FracBitsDefault;
    rsq = longint'(radius) * longint'(radius);
    if (!heading_second && (d1x * d1x + d1y * d1y) < rsq) heading_second = 1'b1;
    stop = (d2x * d2x + d2y * d2y) < rsq;
    c.lin = clip24(lin);
    c.ang = clip24(ang);
    c.phase = cmd_phase;
    c.arrived = 1'b0;
    c.last = !stop;
    cmd_queue.push_back(c);
    if (stop) begin
      c.lin = '0;
      c.ang = '0;
      c.phase = heading_second;
      c.arrived = 1'b1;
      c.last = 1'b1;
      cmd_queue.push_back(c);
      run_done = 1'b1;
    end
  endtask

  task automatic compare_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    steer_cmd_t e;
    if (rst) begin
      goal1_x = '0; goal1_y = '0; goal2_x = '0; goal2_y = '0;
      speed_gain = 16'd6144; turn_gain = 16'd4506; radius = 16'd2048;
      heading_second = 1'b0; run_done = 1'b0;
      cmd_queue.delete();
      errs = 0; used = 0; cmds = 0; stops = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index <= REG_RADIUS) begin
          case (reg_index_t'(cfg_index))
            REG_T1X: goal1_x = cfg_data[TgtW-1:0];
            REG_T1Y: goal1_y = cfg_data[TgtW-1:0];
            REG_T2X: goal2_x = cfg_data[TgtW-1:0];
            REG_T2Y: goal2_y = cfg_data[TgtW-1:0];
            REG_LGAIN: speed_gain = cfg_data[GainW-1:0];
            REG_AGAIN: turn_gain = cfg_data[GainW-1:0];
            default: radius = cfg_data[GainW-1:0];
          endcase
          if (run_done) heading_second = 1'b0;
          run_done = 1'b0;
        end
      end
      if (pose.valid && pose.ready && !run_done) begin
        used++;
        predict_steer(longint'(pose.pose_x), longint'(pose.pose_y), longint'(pose.heading));
      end
      if (command.valid && command.ready) begin
        cmds++;
        if (cmd_queue.size() == 0) begin
          errs++;
          $display("%0t: command with nothing expected, got lin %0d ang %0d", $time,
                   command.linear_velocity, command.angular_velocity);
        end else begin
          e = cmd_queue.pop_front();
          if (e.arrived) stops++;
          compare_field("linear_velocity", e.lin, command.linear_velocity);
          compare_field("angular_velocity", e.ang, command.angular_velocity);
          compare_field("waypoint_phase", e.phase, command.waypoint_phase);
          compare_field("arrived", e.arrived, command.arrived);
          compare_field("last", e.last, command.last);
        end
      end
    end
    fail_count <= errs;
    pending <= cmd_queue.size();
    requests_used <= used;
    commands_seen <= cmds;
    stops_seen <= stops;
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import twgc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int PoseMax = 131071;
  localparam int PoseMin = -131072;
  localparam int HeadLimit = 12868;
  localparam int QuietLimit = 5000;
  localparam int Settle = 40;

  logic clk, rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic idle_on;
  int fail_count, pending, requests_used, commands_seen, stops_seen;
  int quiet;
  int t1x, t1y, t2x, t2y, rad;

  twgc_pose_if pose_ch ();
  twgc_cmd_if cmd_ch ();

  two_waypoint_go_to_goal_controller u_top (
    .clk(clk), .rst(rst), .pose(pose_ch), .command(cmd_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  twgc_cmd_checker u_checker (
    .clk(clk), .rst(rst), .pose(pose_ch), .command(cmd_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .requests_used(requests_used),
    .commands_seen(commands_seen), .stops_seen(stops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) cmd_ch.ready <= 1'b0;
    else cmd_ch.ready <= idle_on ? ($urandom_range(99) >= 31) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int clamp_pose(input int v);
    if (v > PoseMax) return PoseMax;
    if (v < PoseMin) return PoseMin;
    return v;
  endfunction

  function automatic int near(input int centre, input int span);
    return clamp_pose(centre + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic send_pose(input int x, input int y, input int h);
    while (idle_on && $urandom_range(99) < 31) begin
      pose_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.pose_x <= x[17:0];
    pose_ch.pose_y <= y[17:0];
    pose_ch.heading <= h[14:0];
    do @(posedge clk); while (!pose_ch.ready);
  endtask

  task automatic settle();
    pose_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d[CfgDataW-1:0];
    @(posedge clk);
  endtask

  function automatic int pick_coord();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return PoseMax;
    return $urandom_range(PoseMax);
  endfunction

  function automatic int pick_gain();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    return $urandom_range(131071);
  endfunction

  function automatic int pick_heading();
    if ($urandom_range(9) == 0) return $urandom_range(32767);
    return int'($urandom_range(2 * HeadLimit)) - HeadLimit;
  endfunction

  initial begin
    int n, r, used_before;
    rst <= 1'b1;
    idle_on <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pose_ch.valid <= 1'b0;
    pose_ch.pose_x <= '0;
    pose_ch.pose_y <= '0;
    pose_ch.heading <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pose(PoseMin, PoseMin, -HeadLimit);
    send_pose(PoseMax, PoseMax, HeadLimit);
    send_pose(PoseMax, PoseMin, 0);
    send_pose(PoseMin, 0, -16384);
    send_pose(PoseMin, 5, 16383);
    send_pose(0, 0, 0);
    send_pose(100, 100, 100);
    settle();

    write_reg(REG_T1X, PoseMax);
    write_reg(REG_T1Y, PoseMax);
    write_reg(REG_T2X, 0);
    write_reg(REG_T2Y, 0);
    write_reg(REG_LGAIN, 131071);
    write_reg(REG_AGAIN, 131071);
    write_reg(REG_RADIUS, 0);
    write_reg(RegUnused, 131071);
    cfg_we <= 1'b0;
    send_pose(PoseMin, PoseMin, -HeadLimit);
    send_pose(PoseMax, PoseMax, 0);
    send_pose(0, 0, HeadLimit);
    send_pose(PoseMax, PoseMin, -HeadLimit);
    settle();

    write_reg(REG_LGAIN, 0);
    write_reg(REG_AGAIN, 0);
    write_reg(REG_RADIUS, 65535);
    write_reg(REG_T1X, 4096);
    write_reg(REG_T1Y, 4096);
    write_reg(REG_T2X, 40000);
    write_reg(REG_T2Y, 40000);
    cfg_we <= 1'b0;
    send_pose(PoseMin, PoseMin, 0);
    send_pose(4000, 4100, 0);
    send_pose(0, 0, 1000);
    send_pose(40001, 39999, 0);
    send_pose(40000, 40000, 0);
    settle();

    while (requests_used < 2000) begin
      t1x = pick_coord();
      t1y = pick_coord();
      t2x = pick_coord();
      t2y = pick_coord();
      r = $urandom_range(9);
      rad = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(256, 16384);
      write_reg(REG_T1X, t1x);
      write_reg(REG_T1Y, t1y);
      write_reg(REG_T2X, t2x);
      write_reg(REG_T2Y, t2y);
      write_reg(REG_LGAIN, pick_gain());
      write_reg(REG_AGAIN, pick_gain());
      write_reg(REG_RADIUS, rad);
      if ($urandom_range(9) == 0) write_reg(RegUnused, $urandom_range(131071));
      cfg_we <= 1'b0;
      idle_on <= !(requests_used >= 600 && requests_used < 900);
      n = $urandom_range(6, 30);
      used_before = requests_used;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(99);
        if (r < 15) send_pose(int'($urandom_range(262143)) - 131072,
                              int'($urandom_range(262143)) - 131072, pick_heading());
        else if (k < n / 2) send_pose(near(t1x, rad + rad / 2 + 8), near(t1y, rad + rad / 2 + 8),
                                      pick_heading());
        else send_pose(near(t2x, rad + rad / 2 + 8), near(t2y, rad + rad / 2 + 8),
                       pick_heading());
      end
      settle();
    end

    $display("Covered %0d pose requests over many waypoint settings.", requests_used);
    $display("Checked %0d commands, %0d of them stop commands.", commands_seen, stops_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: two_waypoint_go_to_goal_controller.f
design/twgc_pkg.sv
design/twgc_stream_if.sv
design/twgc_datapath.sv
design/twgc_control.sv
design/two_waypoint_go_to_goal_controller.sv
design/twgc_checker.sv
dv/twgc_cmd_checker.sv
dv/tb_top.sv
